// File: rtl/vecc_pkg.sv
// Shared types and constants for the Voronoi edge cell classifier.
`default_nettype none

package vecc_pkg;

   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_MOVE     = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;

   localparam logic CSR_GRID_COLUMNS = 1'b0;
   localparam logic CSR_GRID_ROWS    = 1'b1;

   localparam logic [6:0] GRID_RESET = 7'd64;

   localparam int RESEED_LIMIT = 2400;
   localparam int NEAR_LIMIT   = 1200;
   localparam int GAP_BRIGHT   = 190;
   localparam int GAP_DIM_BASE = 580;
   localparam int GAP_DIM_DIV  = 180;
   localparam logic [3:0] HALF_CELL = 4'd8;
   localparam logic [11:0] TICK_MAX = 12'hFFF;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_MOVE,
      OP_CLASSIFY,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      CLASS_OFF    = 2'd0,
      CLASS_BRIGHT = 2'd1,
      CLASS_DIM    = 2'd2
   } cell_class_type;

   typedef struct packed {
      op_type             op;
      logic [2:0]         slot;
      logic [9:0]         x;
      logic [9:0]         y;
      logic signed [4:0]  vx;
      logic signed [4:0]  vy;
      logic [9:0]         cx;
      logic [9:0]         cy;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/vecc_front.sv
// Front end: accepts request items and decodes them into queue entries.
`default_nettype none

module vecc_front #(
   parameter int SITES = 8
) (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [2:0]        req_site_slot,
   input  logic [9:0]        req_site_x,
   input  logic [9:0]        req_site_y,
   input  logic signed [4:0] req_site_vx,
   input  logic signed [4:0] req_site_vy,
   input  logic [5:0]        req_cell_col,
   input  logic [5:0]        req_cell_row,
   input  logic [6:0]        eff_cols,
   input  logic [6:0]        eff_rows,
   input  logic              q_full,
   output logic              q_push,
   output vecc_pkg::item_type q_item
);
   import vecc_pkg::*;

   logic in_grid;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign in_grid   = ({1'b0, req_cell_col} < eff_cols) && ({1'b0, req_cell_row} < eff_rows);

   always_comb begin
      q_item.slot = req_site_slot;
      q_item.x    = req_site_x;
      q_item.y    = req_site_y;
      q_item.vx   = req_site_vx;
      q_item.vy   = req_site_vy;
      q_item.cx   = {req_cell_col, HALF_CELL};
      q_item.cy   = {req_cell_row, HALF_CELL};
      unique case (req_cmd)
         CMD_LOAD:     q_item.op = (32'(req_site_slot) < SITES) ? OP_LOAD : OP_NONE;
         CMD_MOVE:     q_item.op = OP_MOVE;
         CMD_CLASSIFY: q_item.op = in_grid ? OP_CLASSIFY : OP_NONE;
         default:      q_item.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/vecc_queue.sv
// Short FIFO of decoded items between front and back.
`default_nettype none

module vecc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vecc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output vecc_pkg::item_type pop_item
);
   import vecc_pkg::*;

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W:0]     count_ff;
   logic                     do_push;
   logic                     do_pop;

   assign full      = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff           <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         priority if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end else begin
            count_ff <= count_ff;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/vecc_back.sv
// Back end: site table, move sequencer, shared distance unit and result register.
`default_nettype none

module vecc_back #(
   parameter int SITES = 8,
   parameter int POS_W = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  vecc_pkg::item_type q_item,
   output logic               q_pop,
   input  logic [POS_W-1:0]   max_x,
   input  logic [POS_W-1:0]   max_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_cell_class,
   output logic [11:0]        rsp_tick_count,
   output logic               rsp_reseed_due
);
   import vecc_pkg::*;

   localparam int IDX_W  = $clog2(SITES);
   localparam int SQ_W   = 2 * POS_W;
   localparam int D_W    = SQ_W + 1;
   localparam int PROD_W = D_W + 8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE,
      S_DIST,
      S_DRAIN,
      S_GAP,
      S_CLASS,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0]  p;
      logic signed [4:0] v;
   } axis_type;

   function automatic axis_type move_axis(input logic [POS_W-1:0] p,
                                          input logic signed [4:0] v,
                                          input logic [POS_W-1:0] maxp);
      logic signed [POS_W+1:0] sum;
      axis_type r;
      sum = $signed({2'b00, p}) + $signed({{(POS_W-3){v[4]}}, v});
      priority if (sum < 0) begin
         r.p = '0;
         r.v = -v;
      end else if (sum > $signed({2'b00, maxp})) begin
         r.p = maxp;
         r.v = -v;
      end else begin
         r.p = sum[POS_W-1:0];
         r.v = v;
      end
      return r;
   endfunction

   state_type          state_ff;
   logic [IDX_W-1:0]   idx_ff;
   item_type           cur_ff;
   logic [POS_W-1:0]   pos_x_ff [SITES];
   logic [POS_W-1:0]   pos_y_ff [SITES];
   logic signed [4:0]  vel_x_ff [SITES];
   logic signed [4:0]  vel_y_ff [SITES];
   logic [11:0]        ticks_ff;
   logic [SQ_W-1:0]    sq_x_ff;
   logic [SQ_W-1:0]    sq_y_ff;
   logic [D_W-1:0]     near_ff;
   logic [D_W-1:0]     sec_ff;
   logic               bright_ff;
   logic               gap_low_ff;
   logic [PROD_W-1:0]  prod_ff;
   cell_class_type     class_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_class_ff;
   logic [11:0]        rsp_ticks_ff;
   logic               rsp_reseed_ff;

   logic [POS_W-1:0]        px;
   logic [POS_W-1:0]        py;
   axis_type                ax_in;
   axis_type                ay_in;
   logic signed [POS_W:0]   dx;
   logic signed [POS_W:0]   dy;
   logic signed [2*POS_W+1:0] sqx_full;
   logic signed [2*POS_W+1:0] sqy_full;
   logic [D_W-1:0]          sq_sum;
   logic [D_W-1:0]          gap_in;
   logic [PROD_W-1:0]       prod_in;
   logic                    last_idx;
   logic                    out_free;

   assign px       = pos_x_ff[idx_ff];
   assign py       = pos_y_ff[idx_ff];
   assign ax_in    = move_axis(px, vel_x_ff[idx_ff], max_x);
   assign ay_in    = move_axis(py, vel_y_ff[idx_ff], max_y);
   assign dx       = $signed({1'b0, POS_W'(cur_ff.cx)}) - $signed({1'b0, px});
   assign dy       = $signed({1'b0, POS_W'(cur_ff.cy)}) - $signed({1'b0, py});
   assign sqx_full = dx * dx;
   assign sqy_full = dy * dy;
   assign sq_sum   = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign gap_in   = sec_ff - near_ff;
   // g < base + n/div  <=>  g < base, or div*(g - base + 1) <= n
   assign prod_in  = PROD_W'(gap_in - D_W'(GAP_DIM_BASE - 1)) * PROD_W'(GAP_DIM_DIV);
   assign last_idx = (idx_ff == IDX_W'(SITES - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == S_IDLE) && q_valid;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_class = rsp_class_ff;
   assign rsp_tick_count = rsp_ticks_ff;
   assign rsp_reseed_due = rsp_reseed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SITES; i++) begin
            pos_x_ff[i] <= '0;
            pos_y_ff[i] <= '0;
            vel_x_ff[i] <= '0;
            vel_y_ff[i] <= '0;
         end
      end else begin
         // in S_DONE the result register is reloaded below
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               idx_ff   <= '0;
               class_ff <= CLASS_OFF;
               near_ff  <= '1;
               sec_ff   <= '1;
               if (q_valid) begin
                  cur_ff <= q_item;
                  unique case (q_item.op)
                     OP_LOAD: begin
                        pos_x_ff[IDX_W'(q_item.slot)] <= POS_W'(q_item.x);
                        pos_y_ff[IDX_W'(q_item.slot)] <= POS_W'(q_item.y);
                        vel_x_ff[IDX_W'(q_item.slot)] <= q_item.vx;
                        vel_y_ff[IDX_W'(q_item.slot)] <= q_item.vy;
                        state_ff <= S_DONE;
                     end
                     OP_MOVE:     state_ff <= S_MOVE;
                     OP_CLASSIFY: state_ff <= S_DIST;
                     OP_NONE:     state_ff <= S_DONE;
                  endcase
               end
            end
            S_MOVE: begin
               pos_x_ff[idx_ff] <= ax_in.p;
               vel_x_ff[idx_ff] <= ax_in.v;
               pos_y_ff[idx_ff] <= ay_in.p;
               vel_y_ff[idx_ff] <= ay_in.v;
               idx_ff           <= idx_ff + 1'b1;
               if (last_idx) begin
                  if (ticks_ff != TICK_MAX) begin
                     ticks_ff <= ticks_ff + 1'b1;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DIST, S_DRAIN: begin
               if (state_ff == S_DIST) begin
                  sq_x_ff <= sqx_full[SQ_W-1:0];
                  sq_y_ff <= sqy_full[SQ_W-1:0];
                  idx_ff  <= idx_ff + 1'b1;
               end
               // squares of the previous site arrive registered, behind the index
               if (state_ff == S_DRAIN || idx_ff != '0) begin
                  priority if (sq_sum < near_ff) begin
                     sec_ff  <= near_ff;
                     near_ff <= sq_sum;
                  end else if (sq_sum < sec_ff) begin
                     sec_ff <= sq_sum;
                  end else begin
                     sec_ff <= sec_ff;
                  end
               end
               priority if (state_ff == S_DRAIN) begin
                  state_ff <= S_GAP;
               end else if (last_idx) begin
                  state_ff <= S_DRAIN;
               end else begin
                  state_ff <= state_ff;
               end
            end
            S_GAP: begin
               bright_ff  <= (near_ff < D_W'(NEAR_LIMIT)) || (gap_in < D_W'(GAP_BRIGHT));
               gap_low_ff <= (gap_in < D_W'(GAP_DIM_BASE));
               prod_ff    <= prod_in;
               state_ff   <= S_CLASS;
            end
            S_CLASS: begin
               priority if (bright_ff) begin
                  class_ff <= CLASS_BRIGHT;
               end else if (gap_low_ff || (prod_ff <= PROD_W'(near_ff))) begin
                  class_ff <= CLASS_DIM;
               end else begin
                  class_ff <= CLASS_OFF;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_class_ff  <= class_ff;
                  rsp_ticks_ff  <= ticks_ff;
                  rsp_reseed_ff <= (ticks_ff > 12'(RESEED_LIMIT));
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/voronoi_edge_cell_classifier_core.sv
// Top level of the Voronoi edge cell classifier: grid registers, front, queue, back.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  cmd, site_slot, site_x/y, site_vx/vy, cell_col/row
//   rsp      out        rsp_valid/rsp_stall  cell_class, tick_count, reseed_due
//   csr      in         csr_write            csr_index, csr_data
//
// Load and no-op items go straight to the result step; move updates one site
// per cycle, and classify passes one site per cycle through the shared
// squared-distance unit, then gap and class steps.
// Reset is synchronous; it clears the site table, tick count and queue.
// A two-entry queue lets requests be taken while the back end works or the
// result register is held by rsp_stall.
`default_nettype none

module voronoi_edge_cell_classifier_core #(
   parameter int SITES       = 8,
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic [2:0]        req_site_slot,
   input  logic [9:0]        req_site_x,
   input  logic [9:0]        req_site_y,
   input  logic signed [4:0] req_site_vx,
   input  logic signed [4:0] req_site_vy,
   input  logic [5:0]        req_cell_col,
   input  logic [5:0]        req_cell_row,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_cell_class,
   output logic [11:0]       rsp_tick_count,
   output logic              rsp_reseed_due,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [6:0]        csr_data
);
   import vecc_pkg::*;

   localparam int COL_LIM = (MAX_COLUMNS < 127) ? MAX_COLUMNS : 127;
   localparam int ROW_LIM = (MAX_ROWS < 127) ? MAX_ROWS : 127;
   localparam int DIM_LIM = (COL_LIM > ROW_LIM) ? COL_LIM : ROW_LIM;
   localparam int SPAN_W  = $clog2((DIM_LIM - 1) * 16 + 1);
   localparam int POS_W   = (SPAN_W > 10) ? SPAN_W : 10;

   logic [6:0]       cols_ff;
   logic [6:0]       rows_ff;
   logic [6:0]       eff_cols;
   logic [6:0]       eff_rows;
   logic [6:0]       cols_m1;
   logic [6:0]       rows_m1;
   logic [POS_W-1:0] max_x;
   logic [POS_W-1:0] max_y;
   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_valid;
   item_type         push_item;
   item_type         pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= GRID_RESET;
         rows_ff <= GRID_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GRID_COLUMNS: cols_ff <= csr_data;
            CSR_GRID_ROWS:    rows_ff <= csr_data;
         endcase
      end
   end

   always_comb begin
      priority if (cols_ff == '0) begin
         eff_cols = 7'd1;
      end else if (32'(cols_ff) > MAX_COLUMNS) begin
         eff_cols = 7'(COL_LIM);
      end else begin
         eff_cols = cols_ff;
      end
      priority if (rows_ff == '0) begin
         eff_rows = 7'd1;
      end else if (32'(rows_ff) > MAX_ROWS) begin
         eff_rows = 7'(ROW_LIM);
      end else begin
         eff_rows = rows_ff;
      end
   end

   assign cols_m1 = eff_cols - 7'd1;
   assign rows_m1 = eff_rows - 7'd1;
   assign max_x   = POS_W'({cols_m1, 4'b0000});
   assign max_y   = POS_W'({rows_m1, 4'b0000});

   vecc_front #(
      .SITES(SITES)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_site_slot (req_site_slot),
      .req_site_x    (req_site_x),
      .req_site_y    (req_site_y),
      .req_site_vx   (req_site_vx),
      .req_site_vy   (req_site_vy),
      .req_cell_col  (req_cell_col),
      .req_cell_row  (req_cell_row),
      .eff_cols      (eff_cols),
      .eff_rows      (eff_rows),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   vecc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (pop_item)
   );

   vecc_back #(
      .SITES(SITES),
      .POS_W(POS_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .max_x          (max_x),
      .max_y          (max_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_class (rsp_cell_class),
      .rsp_tick_count (rsp_tick_count),
      .rsp_reseed_due (rsp_reseed_due)
   );

endmodule

`default_nettype wire

// File: tb/tb_voronoi_edge_cell_classifier_core.sv
// Self-checking testbench for the Voronoi edge cell classifier core.
`timescale 1ns / 1ps

module tb_voronoi_edge_cell_classifier_core;
   import vecc_pkg::*;

   localparam int N_SITES     = 8;
   localparam int GRID_MAX    = 64;
   localparam int SUBCELL     = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int N_DIRECTED  = 25;
   localparam logic [1:0] CMD_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [2:0]        slot;
      logic [9:0]        x;
      logic [9:0]        y;
      logic signed [4:0] vx;
      logic signed [4:0] vy;
      logic [5:0]        col;
      logic [5:0]        row;
   } req_item_type;

   typedef struct packed {
      cell_class_type cls;
      logic [11:0]    ticks;
      logic           reseed;
   } response_type;

   typedef struct {
      logic [1:0]     cmd;
      int             slot, x, y, vx, vy, col, row;
      bit             typed;
      cell_class_type cls;
      int             ticks;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_cmd;
   logic [2:0]        req_site_slot;
   logic [9:0]        req_site_x;
   logic [9:0]        req_site_y;
   logic signed [4:0] req_site_vx;
   logic signed [4:0] req_site_vy;
   logic [5:0]        req_cell_col;
   logic [5:0]        req_cell_row;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_cell_class;
   logic [11:0]       rsp_tick_count;
   logic              rsp_reseed_due;
   logic              csr_write;
   logic              csr_index;
   logic [6:0]        csr_data;

   // predictor state
   int                site_px [N_SITES];
   int                site_py [N_SITES];
   logic signed [4:0] site_vx [N_SITES];
   logic signed [4:0] site_vy [N_SITES];
   int                tick_total;
   logic [6:0]        grid_cols;
   logic [6:0]        grid_rows;

   response_type awaited_responses[$];
   response_type no_fixed;
   int           errors;
   int           cycle_count;
   int           stall_left;
   bit           idle_on;

   dir_row_type directed_rows [N_DIRECTED] = '{
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0,  0,  0, 1, CLASS_BRIGHT, 0},
      '{CMD_NONE,     7, 1023, 1023,  -1,  -1, 63, 63, 1, CLASS_OFF,    0},
      '{CMD_MOVE,     0,    0,    0,   0,   0,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_LOAD,     0,    0,    0, -16,  15,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_LOAD,     7, 1023, 1023,  15, -16,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_LOAD,     1, 1008,    0,  10, -10,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_LOAD,     2,    0, 1008, -10,  10,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_LOAD,     3,  504,  504,   0,   0,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_LOAD,     4,  200,  800,   3,  -2,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_LOAD,     5,  800,  200,  -7,   5,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_LOAD,     6,  512,  520,   1,   1,  0,  0, 1, CLASS_OFF,    1},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0, 31, 31, 0, CLASS_OFF,    0},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0, 63, 63, 0, CLASS_OFF,    0},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0,  0, 63, 0, CLASS_OFF,    0},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0, 63,  0, 0, CLASS_OFF,    0},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0, 15, 47, 0, CLASS_OFF,    0},
      '{CMD_MOVE,     0,    0,    0,   0,   0,  0,  0, 0, CLASS_OFF,    0},
      '{CMD_MOVE,     0,    0,    0,   0,   0,  0,  0, 0, CLASS_OFF,    0},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0, 32, 32, 0, CLASS_OFF,    0},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0, 10, 40, 0, CLASS_OFF,    0},
      '{CMD_LOAD,     3,  300,  700,  -1,   1,  0,  0, 1, CLASS_OFF,    3},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0, 20, 20, 0, CLASS_OFF,    0},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0, 45, 12, 0, CLASS_OFF,    0},
      '{CMD_NONE,     0,    0,    0,   0,   0,  0,  0, 1, CLASS_OFF,    3},
      '{CMD_CLASSIFY, 0,    0,    0,   0,   0,  5, 60, 0, CLASS_OFF,    0}
   };

   voronoi_edge_cell_classifier_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_site_slot  (req_site_slot),
      .req_site_x     (req_site_x),
      .req_site_y     (req_site_y),
      .req_site_vx    (req_site_vx),
      .req_site_vy    (req_site_vy),
      .req_cell_col   (req_cell_col),
      .req_cell_row   (req_cell_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_class (rsp_cell_class),
      .rsp_tick_count (rsp_tick_count),
      .rsp_reseed_due (rsp_reseed_due),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int eff_dim(logic [6:0] value, int limit);
      if (value == 7'd0) return 1;
      return (int'(value) > limit) ? limit : int'(value);
   endfunction

   function automatic void bounce(inout int p, inout logic signed [4:0] v, input int limit);
      int nxt;
      nxt = p + int'(v);
      if (nxt < 0 || nxt > limit) begin
         v = -v;
         nxt = (nxt < 0) ? 0 : limit;
      end
      p = nxt;
   endfunction

   function automatic response_type expected_response(req_item_type it);
      response_type res;
      int           cols, rows, cx, cy, dx, dy;
      longint       sq_sum, best, runner, gap;
      cols = eff_dim(grid_cols, GRID_MAX);
      rows = eff_dim(grid_rows, GRID_MAX);
      res.cls = CLASS_OFF;
      case (it.cmd)
         CMD_LOAD: begin
            site_px[it.slot] = int'(it.x);
            site_py[it.slot] = int'(it.y);
            site_vx[it.slot] = it.vx;
            site_vy[it.slot] = it.vy;
         end
         CMD_MOVE: begin
            for (int i = 0; i < N_SITES; i++) begin
               bounce(site_px[i], site_vx[i], (cols - 1) * SUBCELL);
               bounce(site_py[i], site_vy[i], (rows - 1) * SUBCELL);
            end
            if (tick_total < int'(TICK_MAX)) tick_total++;
         end
         CMD_CLASSIFY: begin
            if (int'(it.col) < cols && int'(it.row) < rows) begin
               cx = int'(it.col) * SUBCELL + int'(HALF_CELL);
               cy = int'(it.row) * SUBCELL + int'(HALF_CELL);
               best = 64'hFFFF_FFFF;
               runner = 64'hFFFF_FFFF;
               for (int i = 0; i < N_SITES; i++) begin
                  dx = cx - site_px[i];
                  dy = cy - site_py[i];
                  sq_sum = longint'(dx * dx + dy * dy);
                  if (sq_sum < best) begin
                     runner = best;
                     best = sq_sum;
                  end else if (sq_sum < runner) begin
                     runner = sq_sum;
                  end
               end
               gap = runner - best;
               if (best < NEAR_LIMIT || gap < GAP_BRIGHT) res.cls = CLASS_BRIGHT;
               else if (gap < GAP_DIM_BASE + best / GAP_DIM_DIV) res.cls = CLASS_DIM;
            end
         end
         default: ;
      endcase
      res.ticks = 12'(tick_total);
      res.reseed = tick_total > RESEED_LIMIT;
      return res;
   endfunction

   function automatic req_item_type random_item(int move_pct);
      req_item_type it;
      int           cols, rows, roll;
      cols = eff_dim(grid_cols, GRID_MAX);
      rows = eff_dim(grid_rows, GRID_MAX);
      it.slot = 3'($urandom);
      it.x    = 10'($urandom);
      it.y    = 10'($urandom);
      it.vx   = 5'($urandom);
      it.vy   = 5'($urandom);
      it.col  = 6'($urandom);
      it.row  = 6'($urandom);
      roll = int'($urandom_range(99));
      if (roll < move_pct) begin
         it.cmd = CMD_MOVE;
      end else begin
         roll = int'($urandom_range(99));
         if (roll < 35) it.cmd = CMD_LOAD;
         else if (roll < 95) it.cmd = CMD_CLASSIFY;
         else it.cmd = CMD_NONE;
      end
      if (it.cmd == CMD_LOAD && $urandom_range(9) != 0) begin
         it.x  = 10'($urandom_range((cols - 1) * SUBCELL));
         it.y  = 10'($urandom_range((rows - 1) * SUBCELL));
         it.vx = 5'($urandom_range(20) - 10);
         it.vy = 5'($urandom_range(20) - 10);
      end
      if (it.cmd == CMD_CLASSIFY && $urandom_range(9) != 0) begin
         it.col = 6'($urandom_range(cols - 1));
         it.row = 6'($urandom_range(rows - 1));
      end
      return it;
   endfunction

   task automatic pause(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic drain();
      while (awaited_responses.size() != 0) @(posedge clock);
   endtask

   task automatic sender_gap();
      int roll;
      roll = int'($urandom_range(99));
      if (!idle_on || roll < 55) return;
      if (roll < 92) pause(int'($urandom_range(3, 1)));
      else pause(int'($urandom_range(40, 5)));
   endtask

   task automatic send_item(input req_item_type it, input bit typed,
                            input response_type fixed);
      response_type res;
      @(negedge clock);
      req_cmd       <= it.cmd;
      req_site_slot <= it.slot;
      req_site_x    <= it.x;
      req_site_y    <= it.y;
      req_site_vx   <= it.vx;
      req_site_vy   <= it.vy;
      req_cell_col  <= it.col;
      req_cell_row  <= it.row;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = expected_response(it);
      awaited_responses.push_back(typed ? fixed : res);
   endtask

   task automatic set_grid(logic [6:0] cols, logic [6:0] rows);
      pause(1);
      drain();
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_GRID_COLUMNS;
      csr_data  <= cols;
      @(negedge clock);
      csr_index <= CSR_GRID_ROWS;
      csr_data  <= rows;
      grid_cols = cols;
      grid_rows = rows;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!idle_on || $urandom_range(99) < 65) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         if ($urandom_range(9) == 0) stall_left <= int'($urandom_range(30, 10));
         else stall_left <= int'($urandom_range(2));
      end
   end

   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected item: cell_class %0d tick_count %0d reseed_due %0d",
                     $time, rsp_cell_class, rsp_tick_count, rsp_reseed_due);
            errors++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_cell_class !== want.cls) begin
               $display("%0t: cell_class expected %0d got %0d", $time, want.cls,
                        rsp_cell_class);
               errors++;
            end
            if (rsp_tick_count !== want.ticks) begin
               $display("%0t: tick_count expected %0d got %0d", $time, want.ticks,
                        rsp_tick_count);
               errors++;
            end
            if (rsp_reseed_due !== want.reseed) begin
               $display("%0t: reseed_due expected %0d got %0d", $time, want.reseed,
                        rsp_reseed_due);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      response_type fixed;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_LOAD;
      req_site_slot = '0;
      req_site_x = '0;
      req_site_y = '0;
      req_site_vx = '0;
      req_site_vy = '0;
      req_cell_col = '0;
      req_cell_row = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_GRID_COLUMNS;
      csr_data = '0;
      errors = 0;
      cycle_count = 0;
      stall_left = 0;
      idle_on = 1'b1;
      no_fixed = '0;
      tick_total = 0;
      grid_cols = GRID_RESET;
      grid_rows = GRID_RESET;
      for (int i = 0; i < N_SITES; i++) begin
         site_px[i] = 0;
         site_py[i] = 0;
         site_vx[i] = '0;
         site_vy[i] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         it.cmd  = directed_rows[i].cmd;
         it.slot = 3'(directed_rows[i].slot);
         it.x    = 10'(directed_rows[i].x);
         it.y    = 10'(directed_rows[i].y);
         it.vx   = 5'(directed_rows[i].vx);
         it.vy   = 5'(directed_rows[i].vy);
         it.col  = 6'(directed_rows[i].col);
         it.row  = 6'(directed_rows[i].row);
         fixed.cls    = directed_rows[i].cls;
         fixed.ticks  = 12'(directed_rows[i].ticks);
         fixed.reseed = 1'b0;
         send_item(it, directed_rows[i].typed, fixed);
         sender_gap();
      end

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_grid(7'd64, 7'd64);
            1: set_grid(7'd1, 7'd1);
            2: set_grid(7'd0, 7'd0);
            3: set_grid(7'd127, 7'd127);
            4: set_grid(7'd64, 7'd1);
            5: set_grid(7'd1, 7'd64);
            6: set_grid(7'($urandom_range(64, 2)), 7'($urandom_range(64, 2)));
            default: set_grid(7'($urandom_range(127)), 7'($urandom_range(127)));
         endcase
         idle_on = (p % 3) != 2;
         for (int n = 0; n < 150; n++) begin
            if (p == 3 && n == 80) begin
               pause(1);
               drain();
            end
            send_item(random_item(20), 1'b0, no_fixed);
            sender_gap();
         end
      end

      // run heavy in moves so sites bounce off the walls repeatedly
      set_grid(7'($urandom_range(64, 8)), 7'($urandom_range(64, 8)));
      for (int n = 0; n < 175; n++) begin
         idle_on = ((n / 50) % 2) == 1;
         send_item(random_item(85), 1'b0, no_fixed);
         sender_gap();
      end

      idle_on = 1'b1;
      pause(1);
      drain();
      repeat (40) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
